[sv/assert_macros.svh]
// Assertion macros shared by the console engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[sv/tcce_pkg.sv]
// Types and constants of the text console character engine.
// Depends on nothing; imported by text_console_character_engine, tcce_checker and tb.
package tcce_pkg;

  localparam int FUNC_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int READ_ROW_W  = 5;
  localparam int READ_COL_W  = 7;
  localparam int OUT_ROW_W   = 5;
  localparam int OUT_COL_W   = 7;
  localparam int OFFSET_W    = 11;
  localparam int CELL_W      = CHAR_W + ATTR_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_COLOR = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  localparam logic [CHAR_W-1:0]   CH_BACKSPACE  = 8'h08;
  localparam logic [CHAR_W-1:0]   CH_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0]   CH_NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0]   CH_RETURN     = 8'h0D;
  localparam logic [CHAR_W-1:0]   BLANK_CHAR    = 8'h20;
  localparam logic [ATTR_W-1:0]   RESET_ATTR    = 8'h07;
  localparam logic [OFFSET_W-1:0] PARKED_OFFSET = 11'd2000;
  localparam int                  TAB_STEP      = 4;

endpackage

[sv/tcce_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; used for the screen cell store.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/text_console_character_engine.sv]
// Text console character engine: cell store, cursor, attribute and operation sequencer.
// Depends on tcce_pkg, tcce_ram and assert_macros.svh.
//
//   port group            dir  handshake
//   start/func_i..col_i   in   taken when start high and busy low
//   done_o/cursor_*/cell  out  one-cycle strobe done_o, cannot be held off
//   cfg_we_i/cfg_wdata_i  in   written on any edge with cfg_we_i high
//
// Put without scroll and read step through S_PUT or S_READ, then S_DONE registers the result.
// Clear: the store is filled with blanks, one cell written per cycle.
// Set colour and put that scrolls: one cell
// read and one written per cycle through the store's two ports.
// After reset the store is swept to blanks with busy high.
`include "assert_macros.svh"

module text_console_character_engine #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [tcce_pkg::FUNC_W-1:0]     func_i,
  input  logic [tcce_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcce_pkg::ATTR_W-1:0]     color_i,
  input  logic [tcce_pkg::READ_ROW_W-1:0] read_row_i,
  input  logic [tcce_pkg::READ_COL_W-1:0] read_col_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  output logic                            done_o,
  output logic [tcce_pkg::OUT_ROW_W-1:0]  cursor_row_o,
  output logic [tcce_pkg::OUT_COL_W-1:0]  cursor_col_o,
  output logic [tcce_pkg::OFFSET_W-1:0]   cursor_offset_o,
  output logic [tcce_pkg::CELL_W-1:0]     read_cell_o
);

  import tcce_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_FILL,
    S_SCROLL,
    S_RECOLOR,
    S_READ,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic                    init_q;
  logic                    cfg_q;
  logic [CW-1:0]           idx_q;
  logic [AW-1:0]           wa_q;
  logic                    pend_q;
  logic [RW-1:0]           cursor_row_q;
  logic [CLW-1:0]          cursor_col_q;
  logic [ATTR_W-1:0]       attr_q;
  func_e                   func_q;
  logic [CHAR_W-1:0]       char_q;
  logic [ATTR_W-1:0]       color_q;
  logic [READ_ROW_W-1:0]   read_row_q;
  logic [READ_COL_W-1:0]   read_col_q;
  logic                    done_q;
  logic [OUT_ROW_W-1:0]    cursor_row_out_q;
  logic [OUT_COL_W-1:0]    cursor_col_out_q;
  logic [OFFSET_W-1:0]     cursor_offset_q;
  logic [CELL_W-1:0]       read_cell_q;

  logic [AW-1:0]           cur_addr;
  logic [AW-1:0]           rd_addr;
  logic                    rd_ok;
  logic [RW:0]             put_row;
  logic [CLW:0]            put_col;
  logic                    put_glyph;
  logic                    put_scroll;
  logic                    fill_act;
  logic                    recolor_act;
  logic                    scroll_act;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [CELL_W-1:0]       mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  logic [CELL_W-1:0]       mem_rdata;

  tcce_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign cur_addr    = AW'(int'(cursor_row_q) * COLUMNS + int'(cursor_col_q));
  assign rd_ok       = (int'(read_row_q) < ROWS) && (int'(read_col_q) < COLUMNS);
  assign rd_addr     = AW'(int'(read_row_q) * COLUMNS + int'(read_col_q));
  assign fill_act    = idx_q != CW'(CELLS);
  assign recolor_act = idx_q != CW'(CELLS);
  assign scroll_act  = idx_q != CW'(CELLS - COLUMNS);

  always_comb begin
    put_row   = {1'b0, cursor_row_q};
    put_col   = {1'b0, cursor_col_q};
    put_glyph = 1'b0;
    case (char_q)
      CH_BACKSPACE: begin
        if (cursor_col_q != '0) begin
          put_col = put_col - 1'b1;
        end
      end
      CH_TAB: begin
        put_col       = put_col + (CLW+1)'(TAB_STEP);
        put_col[1:0]  = 2'b00;
      end
      CH_RETURN: begin
        put_col = '0;
      end
      CH_NEWLINE: begin
        put_col = '0;
        put_row = put_row + 1'b1;
      end
      default: begin
        put_glyph = 1'b1;
        put_col   = put_col + 1'b1;
      end
    endcase
    if (int'(put_col) >= COLUMNS) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    put_scroll = int'(put_row) >= ROWS;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wa_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    case (state_q)
      S_PUT: begin
        mem_we    = put_glyph;
        mem_waddr = cur_addr;
        mem_wdata = {attr_q, char_q};
      end
      S_FILL: begin
        mem_we    = fill_act;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = {attr_q, BLANK_CHAR};
      end
      S_SCROLL: begin
        mem_we    = pend_q;
        mem_re    = scroll_act;
        mem_raddr = AW'(idx_q + CW'(COLUMNS));
      end
      S_RECOLOR: begin
        mem_we    = pend_q;
        mem_wdata = {color_q, mem_rdata[CHAR_W-1:0]};
        mem_re    = recolor_act;
      end
      S_READ: begin
        mem_re    = rd_ok;
        mem_raddr = rd_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_FILL;
      init_q           <= 1'b1;
      cfg_q            <= 1'b1;
      idx_q            <= '0;
      wa_q             <= '0;
      pend_q           <= 1'b0;
      cursor_row_q     <= '0;
      cursor_col_q     <= '0;
      attr_q           <= RESET_ATTR;
      func_q           <= FUNC_PUT;
      char_q           <= '0;
      color_q          <= '0;
      read_row_q       <= '0;
      read_col_q       <= '0;
      done_q           <= 1'b0;
      cursor_row_out_q <= '0;
      cursor_col_out_q <= '0;
      cursor_offset_q  <= '0;
      read_cell_q      <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            func_q     <= func_e'(func_i);
            char_q     <= char_code_i;
            color_q    <= color_i;
            read_row_q <= read_row_i;
            read_col_q <= read_col_i;
            idx_q      <= '0;
            pend_q     <= 1'b0;
            case (func_e'(func_i))
              FUNC_PUT: begin
                state_q <= S_PUT;
              end
              FUNC_CLEAR: begin
                cursor_row_q <= '0;
                cursor_col_q <= '0;
                state_q      <= S_FILL;
              end
              FUNC_COLOR: begin
                state_q <= S_RECOLOR;
              end
              default: begin
                state_q <= S_READ;
              end
            endcase
          end
        end
        S_PUT: begin
          cursor_col_q <= put_col[CLW-1:0];
          if (put_scroll) begin
            cursor_row_q <= RW'(ROWS - 1);
            state_q      <= S_SCROLL;
          end else begin
            cursor_row_q <= put_row[RW-1:0];
            state_q      <= S_DONE;
          end
        end
        S_FILL: begin
          if (fill_act) begin
            idx_q <= idx_q + 1'b1;
          end else begin
            init_q  <= 1'b0;
            state_q <= init_q ? S_IDLE : S_DONE;
          end
        end
        S_SCROLL: begin
          if (scroll_act) begin
            wa_q   <= idx_q[AW-1:0];
            pend_q <= 1'b1;
            idx_q  <= idx_q + 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= S_FILL;
            end
          end
        end
        S_RECOLOR: begin
          if (recolor_act) begin
            wa_q   <= idx_q[AW-1:0];
            pend_q <= 1'b1;
            idx_q  <= idx_q + 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              attr_q  <= color_q;
              state_q <= S_DONE;
            end
          end
        end
        S_READ: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          done_q           <= 1'b1;
          cursor_row_out_q <= OUT_ROW_W'(cursor_row_q);
          cursor_col_out_q <= OUT_COL_W'(cursor_col_q);
          cursor_offset_q  <= cfg_q ? OFFSET_W'(cur_addr) : PARKED_OFFSET;
          read_cell_q      <= (func_q == FUNC_READ && rd_ok) ? mem_rdata : '0;
          state_q          <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = state_q != S_IDLE;
  assign done_o          = done_q;
  assign cursor_row_o    = cursor_row_out_q;
  assign cursor_col_o    = cursor_col_out_q;
  assign cursor_offset_o = cursor_offset_q;
  assign read_cell_o     = read_cell_q;

  `ASSERT_STD(a_done_single, done_o |=> !done_o, "result strobe held two cycles")
  `ASSERT_STD(a_accept_busy, start && !busy |=> busy, "accepted item left engine idle")
  `ASSERT_STD(a_cursor_range, state_q == S_DONE |-> int'(cursor_row_q) < ROWS && int'(cursor_col_q) < COLUMNS, "cursor out of range at result")
  `ASSERT_STD(a_waddr_range, mem_we |-> int'(mem_waddr) < CELLS, "cell write beyond store")

endmodule

[sim/tcce_checker.sv]
`timescale 1ns / 100ps
// Checker for the text console character engine: keeps its own screen, cursor and
// attribute model, predicts each result and compares it with the engine's output.
// Depends on tcce_pkg; instantiated by tb beside the engine.
module tcce_checker #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [tcce_pkg::FUNC_W-1:0]     func_i,
  input  logic [tcce_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcce_pkg::ATTR_W-1:0]     color_i,
  input  logic [tcce_pkg::READ_ROW_W-1:0] read_row_i,
  input  logic [tcce_pkg::READ_COL_W-1:0] read_col_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            done_i,
  input  logic [tcce_pkg::OUT_ROW_W-1:0]  cursor_row_i,
  input  logic [tcce_pkg::OUT_COL_W-1:0]  cursor_col_i,
  input  logic [tcce_pkg::OFFSET_W-1:0]   cursor_offset_i,
  input  logic [tcce_pkg::CELL_W-1:0]     read_cell_i,
  output int                              errors_o,
  output int                              pending_o
);

  import tcce_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [OFFSET_W-1:0]  offset;
    logic [CELL_W-1:0]    cell_val;
  } console_result_t;

  logic [CELL_W-1:0] screen_q [CELLS];
  int unsigned       row_q;
  int unsigned       col_q;
  logic [ATTR_W-1:0] attr_q;
  logic              cursor_on_q;
  console_result_t   console_results_q [$];
  int                mismatches;

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic fill_blank();
    for (int i = 0; i < CELLS; i++) screen_q[i] = {attr_q, BLANK_CHAR};
  endtask

  task automatic scroll_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_q[i] = screen_q[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_q[i] = {attr_q, BLANK_CHAR};
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    int unsigned r;
    int unsigned c;
    r = row_q;
    c = col_q;
    case (ch)
      CH_BACKSPACE: if (c != 0) c--;
      CH_TAB:       c = (c + TAB_STEP) & ~(TAB_STEP - 1);
      CH_RETURN:    c = 0;
      CH_NEWLINE: begin
        c = 0;
        r++;
      end
      default: begin
        screen_q[r * COLUMNS + c] = {attr_q, ch};
        c++;
      end
    endcase
    if (c >= COLUMNS) begin
      c = 0;
      r++;
    end
    if (r >= ROWS) begin
      scroll_up();
      r = ROWS - 1;
    end
    row_q = r;
    col_q = c;
  endtask

  task automatic predict_console(func_e f, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] color,
                                 logic [READ_ROW_W-1:0] rr, logic [READ_COL_W-1:0] rc,
                                 output console_result_t res);
    logic [CELL_W-1:0] cell_val;
    cell_val = '0;
    case (f)
      FUNC_PUT:   put_char(ch);
      FUNC_CLEAR: begin
        fill_blank();
        row_q = 0;
        col_q = 0;
      end
      FUNC_COLOR: begin
        for (int i = 0; i < CELLS; i++) screen_q[i] = {color, screen_q[i][CHAR_W-1:0]};
        attr_q = color;
      end
      FUNC_READ: if (rr < ROWS && rc < COLUMNS) cell_val = screen_q[rr * COLUMNS + rc];
      default: ;
    endcase
    res.row      = row_q[OUT_ROW_W-1:0];
    res.col      = col_q[OUT_COL_W-1:0];
    res.offset   = cursor_on_q ? OFFSET_W'(row_q * COLUMNS + col_q) : PARKED_OFFSET;
    res.cell_val = cell_val;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    console_result_t want;
    if (!rst_ni) begin
      attr_q      = RESET_ATTR;
      row_q       = 0;
      col_q       = 0;
      cursor_on_q = 1'b1;
      fill_blank();
      console_results_q.delete();
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) cursor_on_q = cfg_wdata_i;
      if (done_i) begin
        if (console_results_q.size() == 0) begin
          flag_mismatch("result with nothing expected",
                        {cursor_row_i, cursor_col_i, cursor_offset_i, read_cell_i}, '0);
        end else begin
          want = console_results_q.pop_front();
          if (cursor_row_i !== want.row) flag_mismatch("cursor_row", cursor_row_i, want.row);
          if (cursor_col_i !== want.col) flag_mismatch("cursor_col", cursor_col_i, want.col);
          if (cursor_offset_i !== want.offset)
            flag_mismatch("cursor_offset", cursor_offset_i, want.offset);
          if (read_cell_i !== want.cell_val)
            flag_mismatch("read_cell", read_cell_i, want.cell_val);
        end
      end
      if (start_i && busy_i === 1'b0) begin
        predict_console(func_e'(func_i), char_code_i, color_i, read_row_i, read_col_i, want);
        console_results_q.push_back(want);
      end
      errors_o  <= mismatches;
      pending_o <= console_results_q.size();
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Top of the console engine testbench: clock, reset, item stimulus, cursor enable
// writes, stall watchdog and verdict. Depends on tcce_pkg, the engine and tcce_checker.
module tb;
  import tcce_pkg::*;

  localparam int ROWS          = 25;
  localparam int COLUMNS       = 80;
  localparam int STALL_LIMIT   = 20000;
  localparam int SECTION_ITEMS = 40;
  localparam int MIXED_TEXT    = 0;
  localparam int LONG_LINES    = 1;
  localparam int LINE_FEEDS    = 2;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     func_i      = '0;
  logic [CHAR_W-1:0]     char_code_i = '0;
  logic [ATTR_W-1:0]     color_i     = '0;
  logic [READ_ROW_W-1:0] read_row_i  = '0;
  logic [READ_COL_W-1:0] read_col_i  = '0;
  logic                  cfg_we_i    = 1'b0;
  logic                  cfg_wdata_i = 1'b0;
  logic                  done_o;
  logic [OUT_ROW_W-1:0]  cursor_row_o;
  logic [OUT_COL_W-1:0]  cursor_col_o;
  logic [OFFSET_W-1:0]   cursor_offset_o;
  logic [CELL_W-1:0]     read_cell_o;
  int                    errors;
  int                    pending;
  int                    quiet_cycles = 0;
  int                    line_mode    = MIXED_TEXT;

  text_console_character_engine #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .char_code_i     (char_code_i),
    .color_i         (color_i),
    .read_row_i      (read_row_i),
    .read_col_i      (read_col_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_col_o    (cursor_col_o),
    .cursor_offset_o (cursor_offset_o),
    .read_cell_o     (read_cell_o)
  );

  tcce_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .func_i          (func_i),
    .char_code_i     (char_code_i),
    .color_i         (color_i),
    .read_row_i      (read_row_i),
    .read_col_i      (read_col_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_i          (done_o),
    .cursor_row_i    (cursor_row_o),
    .cursor_col_i    (cursor_col_o),
    .cursor_offset_i (cursor_offset_o),
    .read_cell_i     (read_cell_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold the item until taken, then maybe drop start for a short burst
  task automatic send_item(func_e f, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] color,
                           logic [READ_ROW_W-1:0] rr, logic [READ_COL_W-1:0] rc,
                           bit may_idle);
    start       <= 1'b1;
    func_i      <= f;
    char_code_i <= ch;
    color_i     <= color;
    read_row_i  <= rr;
    read_col_i  <= rc;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy !== 1'b0);
  endtask

  task automatic write_cursor_enable(logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char(int mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      LONG_LINES: begin
        if (r < 15) return CH_TAB;
        if (r < 18) return CH_BACKSPACE;
      end
      LINE_FEEDS: begin
        if (r < 35) return CH_NEWLINE;
        if (r < 40) return CH_RETURN;
      end
      default: begin
        if (r < 8) return CH_NEWLINE;
        if (r < 14) return CH_BACKSPACE;
        if (r < 20) return CH_TAB;
        if (r < 25) return CH_RETURN;
      end
    endcase
    return CHAR_W'($urandom);
  endfunction

  task automatic run_random(int count, bit may_idle);
    int unsigned           k;
    logic [READ_ROW_W-1:0] rr;
    logic [READ_COL_W-1:0] rc;
    for (int i = 0; i < count; i++) begin
      if (i % SECTION_ITEMS == 0) line_mode = $urandom_range(MIXED_TEXT, LINE_FEEDS);
      k  = $urandom_range(0, 99);
      rr = ($urandom_range(0, 7) == 0) ? READ_ROW_W'($urandom) :
                                         READ_ROW_W'($urandom_range(0, ROWS - 1));
      rc = ($urandom_range(0, 7) == 0) ? READ_COL_W'($urandom) :
                                         READ_COL_W'($urandom_range(0, COLUMNS - 1));
      if (k < 80)
        send_item(FUNC_PUT, pick_char(line_mode), ATTR_W'($urandom), rr, rc, may_idle);
      else if (k < 96)
        send_item(FUNC_READ, CHAR_W'($urandom), ATTR_W'($urandom), rr, rc, may_idle);
      else if (k < 99)
        send_item(FUNC_COLOR, CHAR_W'($urandom), ATTR_W'($urandom), rr, rc, may_idle);
      else
        send_item(FUNC_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom), rr, rc, may_idle);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);

    send_item(FUNC_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_READ,  8'hFF, 8'hFF, 5'd24, 7'd79,  1'b1);
    send_item(FUNC_READ,  8'h00, 8'h00, 5'd31, 7'd127, 1'b1);
    send_item(FUNC_READ,  8'h00, 8'h00, 5'd25, 7'd0,   1'b1);
    send_item(FUNC_READ,  8'h00, 8'h00, 5'd0,  7'd80,  1'b1);
    send_item(FUNC_PUT,   8'h41, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_PUT,   8'h00, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_PUT,   8'hFF, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_PUT,   CH_BACKSPACE, 8'h00, 5'd0, 7'd0, 1'b1);
    send_item(FUNC_PUT,   CH_RETURN,    8'h00, 5'd0, 7'd0, 1'b1);
    send_item(FUNC_PUT,   CH_BACKSPACE, 8'h00, 5'd0, 7'd0, 1'b1);
    send_item(FUNC_PUT,   CH_TAB,       8'h00, 5'd0, 7'd0, 1'b1);
    send_item(FUNC_PUT,   CH_TAB,       8'h00, 5'd0, 7'd0, 1'b1);
    send_item(FUNC_PUT,   CH_NEWLINE,   8'h00, 5'd0, 7'd0, 1'b1);
    send_item(FUNC_PUT,   8'h7E, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_COLOR, 8'h00, 8'hFF, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_READ,  8'h00, 8'h00, 5'd0,  7'd1,   1'b1);
    send_item(FUNC_PUT,   8'h55, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_COLOR, 8'h00, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_READ,  8'h00, 8'h00, 5'd1,  7'd0,   1'b1);
    send_item(FUNC_CLEAR, 8'h00, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_COLOR, 8'h00, 8'h1E, 5'd0,  7'd0,   1'b1);
    send_item(FUNC_READ,  8'h00, 8'h00, 5'd24, 7'd79,  1'b1);

    wait_idle();
    write_cursor_enable(1'b0);
    run_random(450, 1'b1);
    wait_idle();
    write_cursor_enable(1'b1);
    run_random(450, 1'b1);
    wait_idle();
    write_cursor_enable(1'b0);
    run_random(200, 1'b1);
    wait_idle();
    write_cursor_enable(1'b1);
    run_random(225, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/tcce_pkg.sv
sv/tcce_ram.sv
sv/text_console_character_engine.sv
sim/tcce_checker.sv
sim/tb.sv
